// File: sv/aup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aup_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_W    = 16;
    localparam int RCP_W    = 17;
    localparam int RCP_SH   = 16;
    localparam int N_COLOUR = 3;
    localparam logic [CHAN_W-1:0] MAX_LEVEL = 8'hFF;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [RCP_W-1:0]  rcp_t;
    typedef rcp_t recip_table_t [256];

    // floor(2^16 / a) by restoring long division, evaluated once at elaboration
    function automatic recip_table_t build_recip();
        recip_table_t tbl;
        logic [RCP_W:0]   rem;
        logic [RCP_W-1:0] quo;
        logic [RCP_W-1:0] dividend;
        logic [RCP_W:0]   dvs;
        tbl = '{default: '0};
        dividend = 17'h10000;
        for (int d = 1; d < 256; d++) begin
            rem = '0;
            quo = '0;
            dvs = 18'(d);
            for (int b = RCP_W - 1; b >= 0; b--) begin
                rem = {rem[RCP_W-1:0], dividend[b]};
                if (rem >= dvs) begin
                    rem = rem - dvs;
                    quo[b] = 1'b1;
                end
            end
            tbl[d] = quo;
        end
        return tbl;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip();

endpackage

`default_nettype wire

// File: sv/alpha_unpremultiply_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake          Payload
// in       in_valid/in_stall  alpha, red, green, blue, end_of_frame
// out      out_valid/out_stall alpha_out, red_out, green_out, blue_out, frame_done
//
// Four register stages: numerator and reciprocal lookup, 16x17 multiply,
// 16x8 back-multiply, remainder correction and saturation.
// One item per cycle sustained while out_stall is low.
// Reset clears only the stage valid bits.
// Each stage loads when it is empty or the one after it moves, so bubbles
// are squeezed out under a stall and nothing is dropped or repeated.

module alpha_unpremultiply_pixel (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire aup_pkg::chan_t        alpha,
    input  wire aup_pkg::chan_t        red,
    input  wire aup_pkg::chan_t        green,
    input  wire aup_pkg::chan_t        blue,
    input  wire logic                  end_of_frame,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output aup_pkg::chan_t             alpha_out,
    output aup_pkg::chan_t             red_out,
    output aup_pkg::chan_t             green_out,
    output aup_pkg::chan_t             blue_out,
    output logic                       frame_done
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

    aup_pkg::chan_t s1_alpha_reg, s2_alpha_reg, s3_alpha_reg, s4_alpha_reg;
    logic           s1_eof_reg, s2_eof_reg, s3_eof_reg, s4_eof_reg;
    aup_pkg::rcp_t  s1_rcp_reg;
    aup_pkg::num_t  s1_num_reg [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s2_num_reg [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s2_qe_reg  [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s3_num_reg [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s3_qe_reg  [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s3_qa_reg  [aup_pkg::N_COLOUR];
    aup_pkg::chan_t s4_col_reg [aup_pkg::N_COLOUR];

    aup_pkg::chan_t in_col     [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s1_num_next [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s2_qe_next  [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s3_qa_next  [aup_pkg::N_COLOUR];
    aup_pkg::num_t  s4_rem      [aup_pkg::N_COLOUR];
    aup_pkg::chan_t s4_col_next [aup_pkg::N_COLOUR];
    logic [32:0]    prod_q      [aup_pkg::N_COLOUR];
    logic [23:0]    prod_a      [aup_pkg::N_COLOUR];
    logic [16:0]    quo_fix     [aup_pkg::N_COLOUR];

    assign s4_rdy   = !s4_valid_reg || !out_stall;
    assign s3_rdy   = !s3_valid_reg || s4_rdy;
    assign s2_rdy   = !s2_valid_reg || s3_rdy;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_stall = !s1_rdy;

    assign s1_valid_next = s1_rdy ? in_valid     : s1_valid_reg;
    assign s2_valid_next = s2_rdy ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_rdy ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next = s4_rdy ? s3_valid_reg : s4_valid_reg;

    assign in_col[0] = red;
    assign in_col[1] = green;
    assign in_col[2] = blue;

    always_comb
    begin
        for (int i = 0; i < aup_pkg::N_COLOUR; i++)
        begin
            // c*255 + floor(a/2)
            s1_num_next[i] = {in_col[i], 8'd0} - {8'd0, in_col[i]} + {9'd0, alpha[7:1]};
            // estimate is q or q-1
            prod_q[i]      = {17'd0, s1_num_reg[i]} * {16'd0, s1_rcp_reg};
            s2_qe_next[i]  = prod_q[i][aup_pkg::RCP_SH +: aup_pkg::NUM_W];
            prod_a[i]      = {8'd0, s2_qe_reg[i]} * {16'd0, s2_alpha_reg};
            s3_qa_next[i]  = prod_a[i][15:0];
            s4_rem[i]      = s3_num_reg[i] - s3_qa_reg[i];
            quo_fix[i]     = {1'b0, s3_qe_reg[i]}
                           + 17'(s4_rem[i] >= {8'd0, s3_alpha_reg});
            if (s3_alpha_reg == '0)
                s4_col_next[i] = '0;
            else if (quo_fix[i] > 17'(aup_pkg::MAX_LEVEL))
                s4_col_next[i] = aup_pkg::MAX_LEVEL;
            else
                s4_col_next[i] = quo_fix[i][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_alpha_reg <= alpha;
            s1_eof_reg   <= end_of_frame;
            s1_rcp_reg   <= aup_pkg::RECIP_TABLE[alpha];
            s1_num_reg   <= s1_num_next;
        end
        if (s2_rdy)
        begin
            s2_alpha_reg <= s1_alpha_reg;
            s2_eof_reg   <= s1_eof_reg;
            s2_num_reg   <= s1_num_reg;
            s2_qe_reg    <= s2_qe_next;
        end
        if (s3_rdy)
        begin
            s3_alpha_reg <= s2_alpha_reg;
            s3_eof_reg   <= s2_eof_reg;
            s3_num_reg   <= s2_num_reg;
            s3_qe_reg    <= s2_qe_reg;
            s3_qa_reg    <= s3_qa_next;
        end
        if (s4_rdy)
        begin
            s4_alpha_reg <= s3_alpha_reg;
            s4_eof_reg   <= s3_eof_reg;
            s4_col_reg   <= s4_col_next;
        end
    end

    assign out_valid  = s4_valid_reg;
    assign alpha_out  = s4_alpha_reg;
    assign red_out    = s4_col_reg[0];
    assign green_out  = s4_col_reg[1];
    assign blue_out   = s4_col_reg[2];
    assign frame_done = s4_eof_reg;

    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alpha_out == '0 |-> red_out == '0 && green_out == '0 && blue_out == '0)
        else $error("colour not cleared for zero alpha");

    a_estimate_low: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_qa_reg[0] <= s3_num_reg[0] && s3_qa_reg[1] <= s3_num_reg[1]
                         && s3_qa_reg[2] <= s3_num_reg[2])
        else $error("quotient estimate too high");

    a_one_fix: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_alpha_reg != '0
            |-> s4_rem[0] < {8'd0, s3_alpha_reg, 1'b0} && s4_rem[1] < {8'd0, s3_alpha_reg, 1'b0}
                && s4_rem[2] < {8'd0, s3_alpha_reg, 1'b0})
        else $error("quotient estimate off by more than one");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty first stage");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 250;

    typedef struct {
        aup_pkg::chan_t alpha;
        aup_pkg::chan_t red;
        aup_pkg::chan_t green;
        aup_pkg::chan_t blue;
        logic           eof;
    } pixel_t;

    typedef struct {
        pixel_t px;
        int     idle_pct;
        int     stall_pct;
        bit     drain;
    } job_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    aup_pkg::chan_t alpha = '0;
    aup_pkg::chan_t red = '0;
    aup_pkg::chan_t green = '0;
    aup_pkg::chan_t blue = '0;
    logic           end_of_frame = 1'b0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    aup_pkg::chan_t alpha_out;
    aup_pkg::chan_t red_out;
    aup_pkg::chan_t green_out;
    aup_pkg::chan_t blue_out;
    logic           frame_done;

    job_t   premul_pixels[$];
    pixel_t straight_pixels[$];
    int     rx_stall_pct = 0;
    int     cycle_count = 0;
    int     n_accepted = 0;
    int     n_checked = 0;
    int     n_failures = 0;
    int     n_zero_alpha = 0;
    int     n_saturated = 0;
    int     n_frames = 0;

    alpha_unpremultiply_pixel dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .alpha        (alpha),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .alpha_out    (alpha_out),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .frame_done   (frame_done)
    );

    always #2 clk = ~clk;

    // rounded c*255/a, clipped at full scale; transparent pixels go black
    function automatic aup_pkg::chan_t straighten(aup_pkg::chan_t c, aup_pkg::chan_t a);
        logic [16:0] q;
        if (a == '0)
            return '0;
        q = (17'(c) * 17'(aup_pkg::MAX_LEVEL) + 17'(a >> 1)) / 17'(a);
        if (q > 17'(aup_pkg::MAX_LEVEL))
            return aup_pkg::MAX_LEVEL;
        return q[aup_pkg::CHAN_W-1:0];
    endfunction

    function automatic pixel_t unpremultiply(pixel_t p);
        pixel_t r;
        r.alpha = p.alpha;
        r.red   = straighten(p.red, p.alpha);
        r.green = straighten(p.green, p.alpha);
        r.blue  = straighten(p.blue, p.alpha);
        r.eof   = p.eof;
        return r;
    endfunction

    // mostly well-formed premultiplied colour (not above alpha), some overrange
    function automatic aup_pkg::chan_t random_colour(aup_pkg::chan_t a);
        if ($urandom_range(99) < 85)
            return aup_pkg::chan_t'($urandom_range(a));
        return aup_pkg::chan_t'($urandom);
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int     kind;
        kind = $urandom_range(99);
        if (kind < 5)
            p.alpha = '0;
        else if (kind < 10)
            p.alpha = aup_pkg::MAX_LEVEL;
        else if (kind < 13)
            p.alpha = 8'd1;
        else
            p.alpha = aup_pkg::chan_t'($urandom);
        p.red   = random_colour(p.alpha);
        p.green = random_colour(p.alpha);
        p.blue  = random_colour(p.alpha);
        p.eof   = ($urandom_range(31) == 0);
        return p;
    endfunction

    function automatic void add_job(pixel_t p, int idle_pct, int stall_pct, bit drain);
        job_t j;
        j.px        = p;
        j.idle_pct  = idle_pct;
        j.stall_pct = stall_pct;
        j.drain     = drain;
        premul_pixels.push_back(j);
    endfunction

    function automatic pixel_t px(int a, int r, int g, int b, bit e);
        pixel_t p;
        p.alpha = aup_pkg::chan_t'(a);
        p.red   = aup_pkg::chan_t'(r);
        p.green = aup_pkg::chan_t'(g);
        p.blue  = aup_pkg::chan_t'(b);
        p.eof   = e;
        return p;
    endfunction

    task automatic compare_field(string name, logic [aup_pkg::CHAN_W-1:0] want,
                                 logic [aup_pkg::CHAN_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_failures++;
        end
    endtask

    // driver: a new item may go up only when nothing is presented or the last one was taken
    always @(posedge clk or negedge rst_n)
    begin : drive
        job_t   nxt;
        pixel_t cur;
        bit     taken;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            alpha        <= '0;
            red          <= '0;
            green        <= '0;
            blue         <= '0;
            end_of_frame <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            taken = in_valid;
            if (taken)
            begin
                cur = px(alpha, red, green, blue, end_of_frame);
                straight_pixels.push_back(unpremultiply(cur));
                n_accepted++;
                if (alpha == '0)
                    n_zero_alpha++;
                if (end_of_frame)
                    n_frames++;
                if (alpha != '0 && (red > alpha || green > alpha || blue > alpha))
                    n_saturated++;
            end
            if (premul_pixels.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                nxt = premul_pixels[0];
                if (nxt.drain && (taken || straight_pixels.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else if ($urandom_range(99) < nxt.idle_pct)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    void'(premul_pixels.pop_front());
                    in_valid     <= 1'b1;
                    alpha        <= nxt.px.alpha;
                    red          <= nxt.px.red;
                    green        <= nxt.px.green;
                    blue         <= nxt.px.blue;
                    end_of_frame <= nxt.px.eof;
                    rx_stall_pct <= nxt.stall_pct;
                end
            end
        end
    end

    // monitor: check each taken result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor
        pixel_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (straight_pixels.size() == 0)
                begin
                    $error("result with no item outstanding");
                    n_failures++;
                end
                else
                begin
                    want = straight_pixels.pop_front();
                    compare_field("alpha_out", want.alpha, alpha_out);
                    compare_field("red_out", want.red, red_out);
                    compare_field("green_out", want.green, green_out);
                    compare_field("blue_out", want.blue, blue_out);
                    compare_field("frame_done", {7'd0, want.eof}, {7'd0, frame_done});
                    n_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("alpha_unpremultiply_pixel regression: fail");
            $finish;
        end
    end

    initial
    begin
        int idle_set[5];
        int stall_set[5];
        idle_set  = '{0, 84, 0, 9, 0};
        stall_set = '{0, 0, 84, 9, 0};

        // corners: transparent, opaque, alpha of one, overrange colour, rounding
        add_job(px(0, 0, 0, 0, 0), 0, 0, 0);
        add_job(px(0, 255, 255, 255, 1), 0, 0, 0);
        add_job(px(0, 1, 128, 255, 0), 0, 0, 0);
        add_job(px(255, 0, 0, 0, 0), 0, 0, 0);
        add_job(px(255, 255, 255, 255, 1), 0, 0, 0);
        add_job(px(255, 1, 127, 254, 0), 0, 0, 0);
        add_job(px(1, 0, 1, 255, 0), 0, 0, 0);
        add_job(px(2, 1, 2, 0, 0), 0, 0, 0);
        add_job(px(3, 1, 2, 3, 1), 0, 0, 0);
        add_job(px(10, 200, 11, 10, 0), 0, 0, 0);
        add_job(px(128, 64, 127, 128, 0), 0, 0, 0);
        add_job(px(128, 129, 255, 0, 0), 0, 0, 0);
        add_job(px(254, 254, 253, 255, 1), 0, 0, 0);
        add_job(px(170, 85, 1, 169, 0), 0, 0, 0);
        add_job(px(85, 42, 43, 84, 0), 0, 0, 0);
        add_job(px(127, 63, 64, 126, 1), 0, 0, 0);
        add_job(px(170, 170, 85, 85, 0), 0, 0, 0);

        // each phase opens by letting the pipe run dry first
        for (int ph = 0; ph < 5; ph++)
            for (int i = 0; i < PHASE_ITEMS; i++)
                add_job(random_pixel(), idle_set[ph], stall_set[ph], i == 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (premul_pixels.size() != 0 || in_valid)
            @(posedge clk);
        while (straight_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d pixels over five idle/stall phases, %0d results checked",
                 n_accepted, n_checked);
        $display("%0d transparent, %0d with clipped colour, %0d frame ends",
                 n_zero_alpha, n_saturated, n_frames);
        if (n_failures == 0)
            $display("alpha_unpremultiply_pixel regression: pass");
        else
            $display("alpha_unpremultiply_pixel regression: fail");
        $finish;
    end

endmodule

// File: sim.f
sv/aup_pkg.sv
sv/alpha_unpremultiply_pixel.sv
bench/tb_top.sv
